FILE: design/rlg_pkg.sv
// ----------------------------------------------------------------------------
// rlg_pkg
// Shared constants, types and the microcode table of the restart budget
// generator (Luby or geometric exponent, fixed-point power, saturation).
// ----------------------------------------------------------------------------
package rlg_pkg;

  // field and datapath widths
  localparam int unsigned IDX_FIELD_BITS = 20;
  localparam int unsigned INDEX_BITS     = 20;
  localparam int unsigned FRAC_BITS      = 12;
  localparam int unsigned GF_FRAC        = 12;
  localparam int unsigned GF_BITS        = 16;
  localparam int unsigned FB_BITS        = 16;
  localparam int unsigned BUDGET_BITS    = 31;
  localparam int unsigned SIZE_BITS      = INDEX_BITS + 1;
  // power stays below 2^(31+FRAC) before a multiply, times a Q4.12 factor below 16
  localparam int unsigned POW_BITS       = FRAC_BITS + 35;
  localparam int unsigned HI_TOP         = FRAC_BITS + 30;
  localparam int unsigned ACC_BITS       = FB_BITS + BUDGET_BITS + 1;
  localparam int unsigned CFG_IDX_BITS   = 2;
  localparam int unsigned CFG_DATA_BITS  = 16;
  localparam int unsigned UPC_BITS       = 5;

  localparam logic [BUDGET_BITS-1:0] BUDGET_MAX = '1;

  // register reset values
  localparam logic               LUBY_MODE_RST = 1'b1;
  localparam logic [GF_BITS-1:0] GROWTH_RST    = 16'd8192;
  localparam logic [FB_BITS-1:0] FIRST_RST     = 16'd100;

  // configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_LUBY_MODE = 2'd0,
    CFG_GROWTH    = 2'd1,
    CFG_FIRST     = 2'd2
  } cfg_idx_e;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_SETE,
    OP_GROW,
    OP_SHRINK,
    OP_SUB,
    OP_MULHI,
    OP_MULLO,
    OP_DECE,
    OP_TAKEP,
    OP_FINHI,
    OP_FINLO,
    OP_EMIT
  } op_e;

  // jump conditions
  typedef enum logic [3:0] {
    C_NONE,
    C_ALWAYS,
    C_NO_INPUT,
    C_GEOM,
    C_SIZE_GT_X,
    C_SIZE_HIT,
    C_X_LT_SIZE,
    C_E_ZERO,
    C_HUGE,
    C_SAME,
    C_OUT_BUSY
  } cond_e;

  typedef logic [UPC_BITS-1:0] upc_t;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    upc_t  target;
  } cword_t;

  // program labels
  localparam upc_t S_IDLE = 5'd0;
  localparam upc_t S_UP   = 5'd2;
  localparam upc_t S_DOWN = 5'd4;
  localparam upc_t S_MOD  = 5'd6;
  localparam upc_t S_GEO  = 5'd8;
  localparam upc_t S_POW  = 5'd9;
  localparam upc_t S_FIN  = 5'd15;
  localparam upc_t S_EMIT = 5'd17;

  // microcode rom: jump to target when the condition holds, else next step
  function automatic cword_t ucode(upc_t addr);
    cword_t cw;
    case (addr)
      5'd0:    cw = '{op: OP_LOAD,   cond: C_NO_INPUT,  target: S_IDLE};
      5'd1:    cw = '{op: OP_NOP,    cond: C_GEOM,      target: S_GEO};
      5'd2:    cw = '{op: OP_NOP,    cond: C_SIZE_GT_X, target: S_DOWN};
      5'd3:    cw = '{op: OP_GROW,   cond: C_ALWAYS,    target: S_UP};
      5'd4:    cw = '{op: OP_NOP,    cond: C_SIZE_HIT,  target: S_POW};
      5'd5:    cw = '{op: OP_SHRINK, cond: C_NONE,      target: S_IDLE};
      5'd6:    cw = '{op: OP_NOP,    cond: C_X_LT_SIZE, target: S_DOWN};
      5'd7:    cw = '{op: OP_SUB,    cond: C_ALWAYS,    target: S_MOD};
      5'd8:    cw = '{op: OP_SETE,   cond: C_NONE,      target: S_IDLE};
      5'd9:    cw = '{op: OP_NOP,    cond: C_E_ZERO,    target: S_FIN};
      5'd10:   cw = '{op: OP_NOP,    cond: C_HUGE,      target: S_FIN};
      5'd11:   cw = '{op: OP_MULHI,  cond: C_NONE,      target: S_IDLE};
      5'd12:   cw = '{op: OP_MULLO,  cond: C_NONE,      target: S_IDLE};
      5'd13:   cw = '{op: OP_DECE,   cond: C_SAME,      target: S_FIN};
      5'd14:   cw = '{op: OP_TAKEP,  cond: C_ALWAYS,    target: S_POW};
      5'd15:   cw = '{op: OP_FINHI,  cond: C_NONE,      target: S_IDLE};
      5'd16:   cw = '{op: OP_FINLO,  cond: C_NONE,      target: S_IDLE};
      5'd17:   cw = '{op: OP_EMIT,   cond: C_OUT_BUSY,  target: S_EMIT};
      5'd18:   cw = '{op: OP_NOP,    cond: C_ALWAYS,    target: S_IDLE};
      default: cw = '{op: OP_NOP,    cond: C_ALWAYS,    target: S_IDLE};
    endcase
    return cw;
  endfunction

endpackage

FILE: design/rlg_idx_if.sv
// ----------------------------------------------------------------------------
// rlg_idx_if
// Restart index channel: valid/ready handshake carrying one index word.
// ----------------------------------------------------------------------------
interface rlg_idx_if;
  logic                                valid;
  logic                                ready;
  logic [rlg_pkg::IDX_FIELD_BITS-1:0] restart_index;

  modport source (output valid, output restart_index, input ready);
  modport sink   (input valid, input restart_index, output ready);
endinterface

FILE: design/rlg_bud_if.sv
// ----------------------------------------------------------------------------
// rlg_bud_if
// Conflict budget channel: valid/ready handshake carrying one budget word.
// ----------------------------------------------------------------------------
interface rlg_bud_if;
  logic                             valid;
  logic                             ready;
  logic [rlg_pkg::BUDGET_BITS-1:0] conflict_budget;
  logic                             saturated;

  modport source (output valid, output conflict_budget, output saturated, input ready);
  modport sink   (input valid, input conflict_budget, input saturated, output ready);
endinterface

FILE: design/restart_budget_luby_geometric.sv
// ----------------------------------------------------------------------------
// restart_budget_luby_geometric
// Conflict budget per restart index, driven by a small microcoded sequencer.
// ----------------------------------------------------------------------------
// One index word is taken at a time and gives one budget word. The sequencer
// takes the index and dispatches; geometric mode also copies the index into
// the exponent. In Luby mode the enclosing subsequence is then doubled until
// the last size check finds it larger than the index. Then come the reduction
// levels, some of which subtract, and the final hit check. There are at most
// INDEX_BITS doublings and as many reduction levels. The power loop follows.
// After it, the power is scaled by the first budget and loaded into the output
// register, and the sequencer returns to idle. The power loop runs one Q4.12
// multiply per pass, in high and low halves, once per unit of exponent.
// It ends early when the power reaches the saturation range or stops
// changing. In geometric mode with a factor close to 1.0 this loop can take
// many thousands of passes. The finished budget sits in an output register,
// so the next index is taken while it waits. Configuration writes are taken
// at any time but are meant only for idle periods.
// ----------------------------------------------------------------------------
module restart_budget_luby_geometric (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rlg_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [rlg_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  rlg_idx_if.sink                           idx_i,
  rlg_bud_if.source                         bud_o
);

  // configuration registers
  logic                          luby_mode_q;
  logic [rlg_pkg::GF_BITS-1:0]   growth_q;
  logic [rlg_pkg::FB_BITS-1:0]   first_q;

  // sequencer
  rlg_pkg::upc_t   upc_q, upc_d;
  rlg_pkg::cword_t cw;
  logic            cond_true;

  // datapath
  logic [rlg_pkg::INDEX_BITS-1:0]  x_q, x_d;
  logic [rlg_pkg::SIZE_BITS-1:0]   size_q, size_d;
  logic [rlg_pkg::INDEX_BITS-1:0]  e_q, e_d;
  logic [rlg_pkg::POW_BITS-1:0]    p_q, p_d;
  logic [rlg_pkg::POW_BITS-1:0]    t_q, t_d;
  logic [rlg_pkg::POW_BITS-1:0]    np_q, np_d;
  logic [rlg_pkg::ACC_BITS-1:0]    acc_q, acc_d;

  // output register
  logic                            out_valid_q, out_valid_d;
  logic [rlg_pkg::BUDGET_BITS-1:0] budget_q, budget_d;
  logic                            sat_q, sat_d;

  logic in_fire;
  logic out_busy;
  logic huge;
  logic emit;

  // current control word
  assign cw = rlg_pkg::ucode(upc_q);

  assign idx_i.ready = (cw.op == rlg_pkg::OP_LOAD);
  assign in_fire     = idx_i.valid && idx_i.ready;
  assign out_busy    = out_valid_q && !bud_o.ready;
  assign emit        = (cw.op == rlg_pkg::OP_EMIT) && !out_busy;
  assign huge        = |p_q[rlg_pkg::POW_BITS-1:rlg_pkg::FRAC_BITS+31];

  assign bud_o.valid           = out_valid_q;
  assign bud_o.conflict_budget = budget_q;
  assign bud_o.saturated       = sat_q;

  // jump condition select
  always_comb begin
    case (cw.cond)
      rlg_pkg::C_NONE:      cond_true = 1'b0;
      rlg_pkg::C_ALWAYS:    cond_true = 1'b1;
      rlg_pkg::C_NO_INPUT:  cond_true = !in_fire;
      rlg_pkg::C_GEOM:      cond_true = !luby_mode_q;
      rlg_pkg::C_SIZE_GT_X: cond_true = size_q > {1'b0, x_q};
      rlg_pkg::C_SIZE_HIT:  cond_true = (size_q - 1'b1) == {1'b0, x_q};
      rlg_pkg::C_X_LT_SIZE: cond_true = {1'b0, x_q} < size_q;
      rlg_pkg::C_E_ZERO:    cond_true = (e_q == '0);
      rlg_pkg::C_HUGE:      cond_true = huge;
      rlg_pkg::C_SAME:      cond_true = (np_q == p_q);
      rlg_pkg::C_OUT_BUSY:  cond_true = out_busy;
      default:              cond_true = 1'b0;
    endcase
  end

  // step counter
  always_comb begin
    if (cond_true) begin
      upc_d = cw.target;
    end else begin
      upc_d = upc_q + 1'b1;
    end
  end

  // datapath operations
  always_comb begin
    x_d    = x_q;
    size_d = size_q;
    e_d    = e_q;
    p_d    = p_q;
    t_d    = t_q;
    np_d   = np_q;
    acc_d  = acc_q;
    case (cw.op)
      rlg_pkg::OP_LOAD: begin
        if (in_fire) begin
          x_d    = rlg_pkg::INDEX_BITS'(idx_i.restart_index);
          size_d = rlg_pkg::SIZE_BITS'(1);
          e_d    = '0;
          p_d    = rlg_pkg::POW_BITS'(1) << rlg_pkg::FRAC_BITS;
        end
      end
      rlg_pkg::OP_SETE: begin
        e_d = x_q;
      end
      rlg_pkg::OP_GROW: begin
        e_d    = e_q + 1'b1;
        size_d = {size_q[rlg_pkg::SIZE_BITS-2:0], 1'b1};
      end
      rlg_pkg::OP_SHRINK: begin
        // size is always 2^k-1, so (size-1)/2 is a plain shift
        e_d    = e_q - 1'b1;
        size_d = size_q >> 1;
      end
      rlg_pkg::OP_SUB: begin
        x_d = x_q - size_q[rlg_pkg::INDEX_BITS-1:0];
      end
      rlg_pkg::OP_MULHI: begin
        t_d = rlg_pkg::POW_BITS'(p_q[rlg_pkg::HI_TOP:rlg_pkg::GF_FRAC])
            * rlg_pkg::POW_BITS'(growth_q);
      end
      rlg_pkg::OP_MULLO: begin
        np_d = t_q + rlg_pkg::POW_BITS'(
                 ((rlg_pkg::GF_FRAC+rlg_pkg::GF_BITS)'(p_q[rlg_pkg::GF_FRAC-1:0])
                  * (rlg_pkg::GF_FRAC+rlg_pkg::GF_BITS)'(growth_q)) >> rlg_pkg::GF_FRAC);
      end
      rlg_pkg::OP_DECE: begin
        e_d = e_q - 1'b1;
      end
      rlg_pkg::OP_TAKEP: begin
        p_d = np_q;
      end
      rlg_pkg::OP_FINHI: begin
        acc_d = rlg_pkg::ACC_BITS'(first_q)
              * rlg_pkg::ACC_BITS'(p_q[rlg_pkg::FRAC_BITS+30:rlg_pkg::FRAC_BITS]);
      end
      rlg_pkg::OP_FINLO: begin
        acc_d = acc_q + rlg_pkg::ACC_BITS'(
                  ((rlg_pkg::FB_BITS+rlg_pkg::FRAC_BITS)'(first_q)
                   * (rlg_pkg::FB_BITS+rlg_pkg::FRAC_BITS)'(p_q[rlg_pkg::FRAC_BITS-1:0]))
                  >> rlg_pkg::FRAC_BITS);
      end
      default: begin
      end
    endcase
  end

  // budget saturation and output slot
  always_comb begin
    out_valid_d = out_valid_q;
    budget_d    = budget_q;
    sat_d       = sat_q;
    if (out_valid_q && bud_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
      if (first_q == '0) begin
        budget_d = '0;
        sat_d    = 1'b0;
      end else if (huge || (acc_q[rlg_pkg::ACC_BITS-1:rlg_pkg::BUDGET_BITS] != '0)) begin
        budget_d = rlg_pkg::BUDGET_MAX;
        sat_d    = 1'b1;
      end else begin
        budget_d = acc_q[rlg_pkg::BUDGET_BITS-1:0];
        sat_d    = 1'b0;
      end
    end
  end

  // control and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= rlg_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      luby_mode_q <= rlg_pkg::LUBY_MODE_RST;
      growth_q    <= rlg_pkg::GROWTH_RST;
      first_q     <= rlg_pkg::FIRST_RST;
    end else begin
      upc_q       <= upc_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (rlg_pkg::cfg_idx_e'(cfg_index_i))
          rlg_pkg::CFG_LUBY_MODE: luby_mode_q <= cfg_data_i[0];
          rlg_pkg::CFG_GROWTH:    growth_q    <= cfg_data_i[rlg_pkg::GF_BITS-1:0];
          rlg_pkg::CFG_FIRST:     first_q     <= cfg_data_i[rlg_pkg::FB_BITS-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    x_q      <= x_d;
    size_q   <= size_d;
    e_q      <= e_d;
    p_q      <= p_d;
    t_q      <= t_d;
    np_q     <= np_d;
    acc_q    <= acc_d;
    budget_q <= budget_d;
    sat_q    <= sat_d;
  end

endmodule
